@@ rtl/core/lroa_pkg.sv @@
// ----------------------------------------------------------------------------
// lroa_pkg
// Types, constants and tables shared by the L-route obstacle avoidance block.
// ----------------------------------------------------------------------------
package lroa_pkg;

   localparam int MAX_OBSTACLES_DEF = 64;
   localparam int FRAC_BITS_DEF     = 4;

   localparam int COORD_W = 16;
   localparam int SIZE_W  = 15;
   localparam int CLR_W   = 12;
   localparam int CNT_W   = 7;
   localparam int SKIP_W  = 7;
   localparam int IDX_W   = 6;
   // wide internal coordinate: 16-bit coords plus offsets, sizes and clearance
   localparam int WIDE_W  = 20;

   localparam int NUM_FRAC = 5;
   localparam int NUM_OFFS = 7;

   localparam logic CSR_CLEARANCE = 1'b0;
   localparam logic CSR_COUNT     = 1'b1;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef logic signed [WIDE_W-1:0] wide_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP,
      ST_MUL,
      ST_SEG,
      ST_SCAN,
      ST_NEXT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                    start;
      logic signed [WIDE_W-1:0] ax;
      logic signed [WIDE_W-1:0] ay;
      logic signed [WIDE_W-1:0] bx;
      logic signed [WIDE_W-1:0] by;
   } seg_req_type;

   typedef struct packed {
      logic busy;
      logic done;
      logic blocked;
   } seg_rsp_type;

   function automatic logic [7:0] frac_q8(input logic [2:0] k);
      case (k)
         3'd0:    frac_q8 = 8'd128;
         3'd1:    frac_q8 = 8'd179;
         3'd2:    frac_q8 = 8'd77;
         3'd3:    frac_q8 = 8'd205;
         default: frac_q8 = 8'd51;
      endcase
   endfunction

   // offset pass 0 is none, passes 1..6 are the pixel offsets
   function automatic logic signed [8:0] offset_px(input logic [2:0] o);
      case (o)
         3'd1:    offset_px = 9'sd30;
         3'd2:    offset_px = 9'sd60;
         3'd3:    offset_px = 9'sd100;
         3'd4:    offset_px = -9'sd30;
         3'd5:    offset_px = -9'sd60;
         3'd6:    offset_px = -9'sd100;
         default: offset_px = 9'sd0;
      endcase
   endfunction

endpackage

@@ rtl/core/lroa_if.sv @@
// ----------------------------------------------------------------------------
// lroa channel interfaces
// Valid/ready channels for requests, responses and register writes.
// ----------------------------------------------------------------------------
interface lroa_req_if;
   logic                      valid;
   logic                      ready;
   logic                      kind;
   logic [5:0]                entry_index;
   logic signed [15:0]        box_x;
   logic signed [15:0]        box_y;
   logic [14:0]               box_width;
   logic [14:0]               box_height;
   logic signed [15:0]        start_x;
   logic signed [15:0]        start_y;
   logic signed [15:0]        end_x;
   logic signed [15:0]        end_y;
   logic signed [6:0]         from_index;
   logic signed [6:0]         to_index;
   modport source (output valid, kind, entry_index, box_x, box_y, box_width, box_height,
                   start_x, start_y, end_x, end_y, from_index, to_index, input ready);
   modport sink (input valid, kind, entry_index, box_x, box_y, box_width, box_height,
                 start_x, start_y, end_x, end_y, from_index, to_index, output ready);
endinterface

interface lroa_rsp_if;
   logic               valid;
   logic               ready;
   logic               found;
   logic signed [15:0] point_x;
   logic signed [15:0] point_y;
   modport source (output valid, found, point_x, point_y, input ready);
   modport sink (input valid, found, point_x, point_y, output ready);
endinterface

interface lroa_csr_if;
   logic        valid;
   logic        ready;
   logic [0:0]  index;
   logic [11:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

@@ rtl/core/lroa_seg_check.sv @@
// ----------------------------------------------------------------------------
// lroa_seg_check
// Checks one segment against the obstacle table, one entry per cycle.
// ----------------------------------------------------------------------------
module lroa_seg_check #(
   parameter int MAX_OBSTACLES = 64,
   parameter int FRAC_BITS     = 4
) (
   input  logic                     clock,
   input  logic                     reset,
   input  lroa_pkg::seg_req_type    seg_req,
   output lroa_pkg::seg_rsp_type    seg_rsp,
   input  logic                     wr_en,
   input  logic [((MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1)-1:0] wr_addr,
   input  logic [63:0]              wr_data,
   input  logic [lroa_pkg::CLR_W-1:0] clearance,
   input  logic [$clog2(MAX_OBSTACLES+1)-1:0] count,
   input  logic signed [lroa_pkg::SKIP_W-1:0] skip_a,
   input  logic signed [lroa_pkg::SKIP_W-1:0] skip_b
);
   import lroa_pkg::*;

   localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int NW = $clog2(MAX_OBSTACLES + 1);

   logic [63:0] mem [MAX_OBSTACLES];
   logic [63:0] rd_ff;

   logic          busy_ff, busy_in;
   logic          rdv_ff, rdv_in;
   logic          done_ff, done_in;
   logic          blk_ff, blk_in;
   logic [NW-1:0] addr_ff, addr_in;
   logic [NW-1:0] chk_ff, chk_in;
   wide_type      lx_ff, ly_ff, hx_ff, hy_ff;
   wide_type      lx_in, ly_in, hx_in, hy_in;

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_ff <= mem[addr_ff[AW-1:0]];
   end

   wide_type ex, ey, ex2, ey2, c;
   logic     skip, hit;
   always_comb begin
      c   = wide_type'({1'b0, clearance});
      ex  = wide_type'($signed(rd_ff[63:48])) - c;
      ey  = wide_type'($signed(rd_ff[47:32])) - c;
      ex2 = wide_type'($signed(rd_ff[63:48])) + wide_type'({1'b0, rd_ff[30:16]}) + c;
      ey2 = wide_type'($signed(rd_ff[47:32])) + wide_type'({1'b0, rd_ff[14:0]}) + c;
      skip = ($signed({1'b0, chk_ff}) == skip_a) || ($signed({1'b0, chk_ff}) == skip_b);
      hit  = (lx_ff < ex2) && (hx_ff > ex) && (ly_ff < ey2) && (hy_ff > ey) && !skip;
   end

   always_comb begin
      busy_in = busy_ff;
      rdv_in  = 1'b0;
      done_in = 1'b0;
      blk_in  = blk_ff;
      addr_in = addr_ff;
      chk_in  = chk_ff;
      lx_in = lx_ff; ly_in = ly_ff; hx_in = hx_ff; hy_in = hy_ff;
      if (seg_req.start) begin
         // box is [min, max+one) in each dimension
         lx_in = (seg_req.ax < seg_req.bx) ? seg_req.ax : seg_req.bx;
         ly_in = (seg_req.ay < seg_req.by) ? seg_req.ay : seg_req.by;
         hx_in = ((seg_req.ax < seg_req.bx) ? seg_req.bx : seg_req.ax)
                 + wide_type'(1 << FRAC_BITS);
         hy_in = ((seg_req.ay < seg_req.by) ? seg_req.by : seg_req.ay)
                 + wide_type'(1 << FRAC_BITS);
         blk_in  = 1'b0;
         addr_in = '0;
         if (count == '0) begin
            done_in = 1'b1;
         end else begin
            busy_in = 1'b1;
         end
      end else if (busy_ff) begin
         if (rdv_ff && hit) begin
            blk_in  = 1'b1;
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (rdv_ff && (chk_ff == count - NW'(1))) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else if (addr_ff < count) begin
            rdv_in  = 1'b1;
            chk_in  = addr_ff;
            addr_in = addr_ff + NW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         rdv_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         rdv_ff  <= rdv_in;
         done_ff <= done_in;
      end
      blk_ff  <= blk_in;
      addr_ff <= addr_in;
      chk_ff  <= chk_in;
      lx_ff <= lx_in; ly_ff <= ly_in; hx_ff <= hx_in; hy_ff <= hy_in;
   end

   assign seg_rsp.busy    = busy_ff;
   assign seg_rsp.done    = done_ff;
   assign seg_rsp.blocked = blk_ff;

   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("segment done while busy");
   a_rdv_busy: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> busy_ff) else $error("read valid outside scan");
   a_chk_range: assert property (@(posedge clock) disable iff (reset)
      rdv_ff |-> chk_ff < count) else $error("checked entry beyond count");
endmodule

@@ rtl/core/l_route_obstacle_avoidance.sv @@
// ----------------------------------------------------------------------------
// l_route_obstacle_avoidance
// Obstacle table with an iterative L-route bend point search.
// ----------------------------------------------------------------------------
// A load request writes one table entry and answers on the next cycle. A query
// tries up to 70 bend candidates, three segments each; every segment reads the
// table once per cycle through a single memory port. The block takes no request
// while a query runs or a response waits. Loads to a slot beyond the table are
// dropped. Unwritten entries below obstacle_count read as garbage.
module l_route_obstacle_avoidance #(
   parameter int MAX_OBSTACLES = lroa_pkg::MAX_OBSTACLES_DEF,
   parameter int FRAC_BITS     = lroa_pkg::FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lroa_req_if.sink   req,
   lroa_rsp_if.source rsp,
   lroa_csr_if.sink   csr
);
   import lroa_pkg::*;

   localparam int AW = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int NW = $clog2(MAX_OBSTACLES + 1);

   state_type state_ff, state_in;
   logic [CLR_W-1:0] clr_ff;
   logic [NW-1:0]    cnt_ff;
   logic signed [COORD_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;
   logic signed [SKIP_W-1:0]  fa_ff, fb_ff;
   logic [2:0] k_ff, k_in, o_ff, o_in;
   logic       vert_ff, vert_in;
   logic [1:0] seg_ff, seg_in;
   wide_type   bx_ff, by_ff, bx_in, by_in;
   wide_type   prod_ff, prod_in;
   logic       rv_ff, rv_in;
   logic       fnd_ff, fnd_in;
   logic signed [COORD_W-1:0] px_ff, py_ff, px_in, py_in;
   logic       lat_q, lat_l;
   logic       wr_ok;
   seg_req_type sreq;
   seg_rsp_type srsp;

   assign req.ready = (state_ff == ST_IDLE) && !rv_ff;
   assign csr.ready = 1'b1;
   assign lat_q = req.valid && req.ready && (req.kind == KIND_QUERY);
   assign lat_l = req.valid && req.ready && (req.kind == KIND_LOAD);
   assign wr_ok = lat_l && (int'(req.entry_index) < MAX_OBSTACLES);

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= CLR_W'(160);
         cnt_ff <= '0;
      end else if (csr.valid) begin
         unique case (csr.index)
            CSR_CLEARANCE: clr_ff <= csr.data;
            CSR_COUNT: begin
               cnt_ff <= ({5'd0, csr.data[6:0]} > 12'(MAX_OBSTACLES))
                         ? NW'(MAX_OBSTACLES) : NW'(csr.data[6:0]);
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (lat_q) begin
         sx_ff <= req.start_x; sy_ff <= req.start_y;
         ex_ff <= req.end_x;   ey_ff <= req.end_y;
         fa_ff <= req.from_index; fb_ff <= req.to_index;
      end
   end

   lroa_seg_check #(.MAX_OBSTACLES(MAX_OBSTACLES), .FRAC_BITS(FRAC_BITS)) u_seg (
      .clock(clock), .reset(reset), .seg_req(sreq), .seg_rsp(srsp),
      .wr_en(wr_ok), .wr_addr(AW'(req.entry_index)),
      .wr_data({req.box_x, req.box_y, 1'b0, req.box_width, 1'b0, req.box_height}),
      .clearance(clr_ff), .count(cnt_ff), .skip_a(fa_ff), .skip_b(fb_ff));

   // shared multiplier: floor(d * frac / 256) via arithmetic shift
   logic signed [16:0] d_sel;
   logic signed [26:0] mul;
   wide_type off, sxw, syw, exw, eyw;
   always_comb begin
      d_sel = vert_ff ? (17'(ey_ff) - 17'(sy_ff)) : (17'(ex_ff) - 17'(sx_ff));
      mul   = 27'(d_sel) * $signed({1'b0, frac_q8(k_ff)});
      off   = wide_type'(offset_px(o_ff)) <<< FRAC_BITS;
      sxw = wide_type'(sx_ff); syw = wide_type'(sy_ff);
      exw = wide_type'(ex_ff); eyw = wide_type'(ey_ff);
   end

   function automatic logic signed [COORD_W-1:0] sat(input wide_type v);
      if (v > wide_type'(32767))       sat = 16'sh7fff;
      else if (v < wide_type'(-32768)) sat = 16'sh8000;
      else                             sat = v[COORD_W-1:0];
   endfunction

   always_comb begin
      state_in = state_ff;
      k_in = k_ff; o_in = o_ff; vert_in = vert_ff; seg_in = seg_ff;
      bx_in = bx_ff; by_in = by_ff; prod_in = prod_ff;
      rv_in = rv_ff; fnd_in = fnd_ff; px_in = px_ff; py_in = py_ff;
      sreq = '0;
      if (rv_ff && rsp.ready) rv_in = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (lat_l) begin
               rv_in = 1'b1; fnd_in = 1'b0; px_in = '0; py_in = '0;
            end else if (lat_q) begin
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            k_in = '0; o_in = '0; vert_in = 1'b0;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            prod_in  = wide_type'(mul >>> 8);
            state_in = ST_SEG;
            seg_in   = '0;
         end
         ST_SEG: begin
            if (!vert_ff) begin
               bx_in = sxw + prod_ff; by_in = syw + off;
            end else begin
               bx_in = sxw + off;     by_in = syw + prod_ff;
            end
            sreq.start = 1'b1;
            sreq.ax = sxw; sreq.ay = syw;
            sreq.bx = bx_in; sreq.by = by_in;
            state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (srsp.done) begin
               if (srsp.blocked) begin
                  state_in = ST_NEXT;
               end else if (seg_ff == 2'd2) begin
                  rv_in = 1'b1; fnd_in = 1'b1;
                  px_in = sat(bx_ff); py_in = sat(by_ff);
                  state_in = ST_IDLE;
               end else begin
                  sreq.start = 1'b1;
                  if (seg_ff == 2'd0) begin
                     sreq.ax = bx_ff; sreq.ay = by_ff;
                     sreq.bx = vert_ff ? exw : bx_ff;
                     sreq.by = vert_ff ? by_ff : eyw;
                  end else begin
                     sreq.ax = vert_ff ? exw : bx_ff;
                     sreq.ay = vert_ff ? by_ff : eyw;
                     sreq.bx = exw; sreq.by = eyw;
                  end
                  seg_in = seg_ff + 2'd1;
               end
            end
         end
         ST_NEXT: begin
            state_in = ST_MUL;
            if (!vert_ff) begin
               vert_in = 1'b1;
            end else begin
               vert_in = 1'b0;
               if (k_ff == 3'(NUM_FRAC - 1)) begin
                  k_in = '0;
                  if (o_ff == 3'(NUM_OFFS - 1)) state_in = ST_DONE;
                  else o_in = o_ff + 3'd1;
               end else begin
                  k_in = k_ff + 3'd1;
               end
            end
         end
         ST_DONE: begin
            rv_in = 1'b1; fnd_in = 1'b0;
            px_in = -16'sd1 <<< FRAC_BITS; py_in = -16'sd1 <<< FRAC_BITS;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      k_ff <= k_in; o_ff <= o_in; vert_ff <= vert_in; seg_ff <= seg_in;
      bx_ff <= bx_in; by_ff <= by_in; prod_ff <= prod_in;
      fnd_ff <= fnd_in; px_ff <= px_in; py_ff <= py_in;
   end

   assign rsp.valid   = rv_ff;
   assign rsp.found   = fnd_ff;
   assign rsp.point_x = px_ff;
   assign rsp.point_y = py_ff;

   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req.ready) else $error("ready during query");
   a_hold_rsp: assert property (@(posedge clock) disable iff (reset)
      (rv_ff && !rsp.ready) |=> rv_ff && $stable(px_ff)) else $error("response lost");
   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      sreq.start |-> !srsp.busy) else $error("segment restarted while busy");
endmodule

@@ bench/l_route_obstacle_avoidance_tb.sv @@
// ----------------------------------------------------------------------------
// l_route_obstacle_avoidance_tb
// Self-checking bench for the L-route bend point search. A directed table
// covers extremes, blocked and skipped obstacles and count saturation; random
// loads and queries follow under several register settings and stall mixes.
// Every response is compared with an in-bench prediction of the search.
// ----------------------------------------------------------------------------
module l_route_obstacle_avoidance_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import lroa_pkg::*;

   typedef struct {
      logic               kind;
      logic [5:0]         entry_index;
      logic signed [15:0] box_x, box_y;
      logic [14:0]        box_width, box_height;
      logic signed [15:0] start_x, start_y, end_x, end_y;
      logic signed [6:0]  from_index, to_index;
   } request_type;

   typedef struct packed {
      logic               found;
      logic signed [15:0] point_x;
      logic signed [15:0] point_y;
   } bend_type;

   typedef enum logic {ROW_ITEM, ROW_CSR} row_op_type;

   typedef struct {
      row_op_type  op;
      logic        csr_index;
      logic [11:0] csr_data;
      request_type item;
      bit          typed;
      bend_type    want;
   } row_type;

   logic clock;
   logic reset;

   lroa_req_if req ();
   lroa_rsp_if rsp ();
   lroa_csr_if csr ();

   l_route_obstacle_avoidance dut (
      .clock (clock),
      .reset (reset),
      .req   (req.sink),
      .rsp   (rsp.source),
      .csr   (csr.sink)
   );

   // bench copy of the block state
   longint obs_x [64];
   longint obs_y [64];
   longint obs_w [64];
   longint obs_h [64];
   bit     obs_loaded [64];
   longint clearance_q4;
   longint count_reg;

   bend_type bend_q[$];
   int       errors;
   int       send_idle_pct;
   int       recv_idle_pct;
   row_type  dir_rows[$];

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #200ms;
      $display("[l_route_obstacle_avoidance] ERROR");
      $finish;
   end

   function automatic longint frac_of(int k);
      case (k)
         0:       frac_of = 128;
         1:       frac_of = 179;
         2:       frac_of = 77;
         3:       frac_of = 205;
         default: frac_of = 51;
      endcase
   endfunction

   function automatic longint shift_of(int o);
      case (o)
         0:       shift_of = 30 * 16;
         1:       shift_of = 60 * 16;
         2:       shift_of = 100 * 16;
         3:       shift_of = -30 * 16;
         4:       shift_of = -60 * 16;
         5:       shift_of = -100 * 16;
         default: shift_of = 0;
      endcase
   endfunction

   function automatic longint floor_q8(longint d, longint f);
      longint p;
      p = d * f;
      if (p >= 0) return p / 256;
      return -((-p + 255) / 256);
   endfunction

   function automatic logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7fff;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
   endfunction

   function automatic longint mag(longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic bit seg_hit(longint ax, longint ay, longint bx, longint by,
                                  longint fa, longint fb);
      longint lx, ly, lw, lh, ex, ey, ew, eh, n;
      lx = (ax < bx) ? ax : bx;
      ly = (ay < by) ? ay : by;
      lw = mag(bx - ax) + 16;
      lh = mag(by - ay) + 16;
      n  = (count_reg > 64) ? 64 : count_reg;
      for (int i = 0; i < n; i++) begin
         if (i == fa || i == fb) continue;
         ex = obs_x[i] - clearance_q4;
         ey = obs_y[i] - clearance_q4;
         ew = obs_w[i] + 2 * clearance_q4;
         eh = obs_h[i] + 2 * clearance_q4;
         if (lx < ex + ew && lx + lw > ex && ly < ey + eh && ly + lh > ey) return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic bit path_hit(longint sx, longint sy, longint px, longint py,
                                   longint cx, longint cy, longint ex, longint ey,
                                   longint fa, longint fb);
      return seg_hit(sx, sy, px, py, fa, fb) || seg_hit(px, py, cx, cy, fa, fb) ||
             seg_hit(cx, cy, ex, ey, fa, fb);
   endfunction

   // updates the table on a load, searches the bend candidates on a query
   function automatic bend_type find_bend(request_type r);
      bend_type b;
      longint   sx, sy, ex, ey, dx, dy, fa, fb, off, hx, hy, vx, vy;
      b = '{1'b0, 16'sd0, 16'sd0};
      if (r.kind == KIND_LOAD) begin
         obs_x[r.entry_index] = r.box_x;
         obs_y[r.entry_index] = r.box_y;
         obs_w[r.entry_index] = r.box_width;
         obs_h[r.entry_index] = r.box_height;
         obs_loaded[r.entry_index] = 1'b1;
         return b;
      end
      sx = r.start_x; sy = r.start_y; ex = r.end_x; ey = r.end_y;
      fa = r.from_index; fb = r.to_index;
      dx = ex - sx;
      dy = ey - sy;
      for (int o = -1; o < 6; o++) begin
         off = shift_of(o);
         for (int k = 0; k < 5; k++) begin
            hx = sx + floor_q8(dx, frac_of(k));
            hy = sy + off;
            vx = sx + off;
            vy = sy + floor_q8(dy, frac_of(k));
            if (!path_hit(sx, sy, hx, hy, hx, ey, ex, ey, fa, fb))
               return '{1'b1, clip16(hx), clip16(hy)};
            if (!path_hit(sx, sy, vx, vy, ex, vy, ex, ey, fa, fb))
               return '{1'b1, clip16(vx), clip16(vy)};
         end
      end
      return '{1'b0, -16'sd16, -16'sd16};
   endfunction

   function automatic request_type noise_item();
      request_type r;
      r.kind        = 1'($urandom_range(1));
      r.entry_index = 6'($urandom);
      r.box_x       = 16'($urandom);
      r.box_y       = 16'($urandom);
      r.box_width   = 15'($urandom);
      r.box_height  = 15'($urandom);
      r.start_x     = 16'($urandom);
      r.start_y     = 16'($urandom);
      r.end_x       = 16'($urandom);
      r.end_y       = 16'($urandom);
      r.from_index  = 7'($urandom);
      r.to_index    = 7'($urandom);
      return r;
   endfunction

   function automatic request_type load_of(int idx, int x, int y, int w, int h);
      request_type r;
      r = noise_item();
      r.kind = KIND_LOAD;
      r.entry_index = 6'(idx);
      r.box_x = 16'(x); r.box_y = 16'(y); r.box_width = 15'(w); r.box_height = 15'(h);
      return r;
   endfunction

   function automatic request_type query_of(int sx, int sy, int ex, int ey, int fa,
                                            int fb);
      request_type r;
      r = noise_item();
      r.kind = KIND_QUERY;
      r.start_x = 16'(sx); r.start_y = 16'(sy); r.end_x = 16'(ex); r.end_y = 16'(ey);
      r.from_index = 7'(fa); r.to_index = 7'(fb);
      return r;
   endfunction

   function automatic int near_coord();
      return $urandom_range(8000) - 4000;
   endfunction

   function automatic request_type small_load(int idx);
      return load_of(idx, near_coord(), near_coord(), $urandom_range(1600),
                     $urandom_range(1600));
   endfunction

   // mostly routes between table obstacles that skip their own ends
   function automatic request_type random_item();
      int n, a, b, qsx, qsy, qex, qey;
      n = (count_reg > 64) ? 64 : int'(count_reg);
      if ($urandom_range(99) < 15) begin
         request_type r;
         r = noise_item();
         if (r.kind == KIND_QUERY || obs_loaded[r.entry_index] || r.entry_index < n)
            return r;
         return small_load(r.entry_index);
      end
      if ($urandom_range(99) < 35) return small_load($urandom_range(15));
      if (n == 0) return query_of(near_coord(), near_coord(), near_coord(), near_coord(),
                                  -1, -1);
      a = $urandom_range(n - 1);
      b = $urandom_range(n - 1);
      qsx = int'(obs_x[a]) + $urandom_range(int'(obs_w[a]));
      qsy = int'(obs_y[a]) + $urandom_range(int'(obs_h[a]));
      qex = int'(obs_x[b]) + $urandom_range(int'(obs_w[b]));
      qey = int'(obs_y[b]) + $urandom_range(int'(obs_h[b]));
      return query_of(qsx, qsy, qex, qey,
                      ($urandom_range(9) == 0) ? -1 : a, ($urandom_range(9) == 0) ? -1 : b);
   endfunction

   task automatic send_request(request_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid = 1'b0;
         @(negedge clock);
      end
      req.valid       = 1'b1;
      req.kind        = r.kind;
      req.entry_index = r.entry_index;
      req.box_x       = r.box_x;
      req.box_y       = r.box_y;
      req.box_width   = r.box_width;
      req.box_height  = r.box_height;
      req.start_x     = r.start_x;
      req.start_y     = r.start_y;
      req.end_x       = r.end_x;
      req.end_y       = r.end_y;
      req.from_index  = r.from_index;
      req.to_index    = r.to_index;
      do @(posedge clock); while (!req.ready);
      bend_q = {bend_q, find_bend(r)};
      @(negedge clock);
   endtask

   task automatic write_reg(logic idx, logic [11:0] data);
      // slots that a larger count would read must hold a rectangle first
      if (idx == CSR_COUNT)
         for (int i = 0; i < ((data[6:0] > 7'd64) ? 64 : int'(data[6:0])); i++)
            if (!obs_loaded[i]) send_request(small_load(i));
      req.valid = 1'b0;
      while (bend_q.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr.valid = 1'b1;
      csr.index = idx;
      csr.data  = data;
      do @(posedge clock); while (!csr.ready);
      if (idx == CSR_CLEARANCE) clearance_q4 = data;
      else count_reg = data[6:0];
      @(negedge clock);
      csr.valid = 1'b0;
   endtask

   function automatic row_type item_row(request_type r, bit typed, bend_type want);
      row_type w;
      w.op = ROW_ITEM; w.item = r; w.typed = typed; w.want = want;
      w.csr_index = 1'b0; w.csr_data = '0;
      return w;
   endfunction

   function automatic row_type csr_row(logic idx, int data);
      row_type w;
      w.op = ROW_CSR; w.csr_index = idx; w.csr_data = 12'(data);
      w.item = noise_item(); w.typed = 1'b0; w.want = '{1'b0, 16'sd0, 16'sd0};
      return w;
   endfunction

   function automatic void add_row(row_type w);
      dir_rows = {dir_rows, w};
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (bend_q.size() == 0) begin
            $display("%0t: unexpected response found=%0b x=%0d y=%0d", $realtime,
                     rsp.found, rsp.point_x, rsp.point_y);
            errors++;
         end else begin
            bend_type e;
            e = bend_q.pop_front();
            if (rsp.found !== e.found || rsp.point_x !== e.point_x ||
                rsp.point_y !== e.point_y) begin
               $display("%0t: expected found=%0b x=%0d y=%0d, actual found=%0b x=%0d y=%0d",
                        $realtime, e.found, e.point_x, e.point_y,
                        rsp.found, rsp.point_x, rsp.point_y);
               errors++;
            end
         end
      end
   end

   initial begin
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp.ready = ($urandom_range(99) >= recv_idle_pct);
      end
   end

   initial begin
      bend_type zero, none;
      int       clr_set [6];
      int       cnt_set [6];
      int       per_phase;
      zero = '{1'b0, 16'sd0, 16'sd0};
      none = '{1'b0, -16'sd16, -16'sd16};
      errors = 0;
      send_idle_pct = 31;
      recv_idle_pct = 72;
      reset = 1'b1;
      req.valid = 1'b0;
      csr.valid = 1'b0;
      csr.index = CSR_CLEARANCE;
      csr.data = '0;
      {req.kind, req.entry_index, req.box_x, req.box_y, req.box_width, req.box_height} = '0;
      {req.start_x, req.start_y, req.end_x, req.end_y, req.from_index, req.to_index} = '0;
      for (int i = 0; i < 64; i++) begin
         obs_x[i] = 0; obs_y[i] = 0; obs_w[i] = 0; obs_h[i] = 0; obs_loaded[i] = 1'b0;
      end
      clearance_q4 = 160;
      count_reg = 0;
      repeat (7) @(negedge clock);
      reset = 1'b0;

      add_row(item_row(load_of(0, -32768, 32767, 32767, 0), 1, zero));
      add_row(item_row(load_of(63, 32767, -32768, 0, 32767), 1, zero));
      add_row(item_row(query_of(0, 0, 160, 320, -1, -1), 1, '{1'b1, 16'sd80, 16'sd0}));
      add_row(item_row(query_of(-32768, -32768, 32767, 32767, -64, 63), 1,
                       '{1'b1, -16'sd1, -16'sd32768}));
      add_row(item_row(query_of(32767, 32767, -32768, -32768, 63, -64), 1,
                       '{1'b1, -16'sd1, 16'sd32767}));
      add_row(item_row(load_of(0, -32768, -32768, 32767, 32767), 1, zero));
      add_row(item_row(load_of(1, 0, 0, 32767, 32767), 1, zero));
      add_row(csr_row(CSR_COUNT, 2));
      // start buried inside an obstacle: nothing can be free
      add_row(item_row(query_of(-1600, -1600, 1600, 1600, -1, -1), 1, none));
      add_row(item_row(query_of(-1600, -1600, 1600, 1600, 0, 1), 0, zero));
      add_row(item_row(query_of(-1600, -1600, 1600, 1600, 0, -1), 0, zero));
      add_row(csr_row(CSR_CLEARANCE, 4095));
      add_row(item_row(query_of(-16000, 16000, -15000, 17000, -1, -1), 0, zero));
      add_row(csr_row(CSR_CLEARANCE, 0));
      add_row(item_row(query_of(-16000, 16000, -15000, 17000, -1, -1), 0, zero));
      add_row(item_row(query_of(32000, 32000, 32767, 32767, -1, -1), 0, zero));
      // count above the table depth saturates
      add_row(csr_row(CSR_COUNT, 127));
      add_row(item_row(query_of(0, 0, 320, 320, -1, -1), 0, zero));
      add_row(item_row(query_of(-3000, 2000, 3000, -2000, 5, 9), 0, zero));
      add_row(csr_row(CSR_COUNT, 0));

      foreach (dir_rows[i]) begin
         if (dir_rows[i].op == ROW_CSR) begin
            write_reg(dir_rows[i].csr_index, dir_rows[i].csr_data);
         end else begin
            if (dir_rows[i].typed) begin
               bend_type p;
               p = find_bend(dir_rows[i].item);
               if (p != dir_rows[i].want) begin
                  $display("%0t: table row %0d disagrees with prediction", $realtime, i);
                  errors++;
               end
               for (int k = 0; k < 64; k++) obs_loaded[k] = obs_loaded[k];
            end
            send_request(dir_rows[i].item);
         end
      end

      clr_set = '{0, 4095, $urandom_range(4095), 16, $urandom_range(4095), 160};
      cnt_set = '{3, 2, $urandom_range(10), 64, $urandom_range(127, 65), 6};
      for (int ph = 0; ph < 6; ph++) begin
         write_reg(CSR_CLEARANCE, 12'(clr_set[ph]));
         write_reg(CSR_COUNT, 12'(cnt_set[ph]));
         if (ph == 2) begin
            send_idle_pct = 72; recv_idle_pct = 31;
         end else if (ph == 4) begin
            send_idle_pct = 0; recv_idle_pct = 0;
         end
         // dense tables make failing queries slow, so keep those phases short
         per_phase = (cnt_set[ph] >= 64) ? 3 : 6;
         for (int n = 0; n < per_phase; n++) send_request(random_item());
      end
      req.valid = 1'b0;

      while (bend_q.size() != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (errors == 0) begin
         $display("[l_route_obstacle_avoidance] OK");
      end else begin
         $display("[l_route_obstacle_avoidance] ERROR");
      end
      $finish;
   end

endmodule
